// ===== rtl/core/dhskt_pkg.sv =====
// ----------------------------------------------------------------------------
// dhskt_pkg
// Types and constants for the double-hashed string key table.
// ----------------------------------------------------------------------------
package dhskt_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam int          MAX_KEY_BYTES = 15;

   localparam logic       KIND_INSERT = 1'b0;
   localparam logic       KIND_SEARCH = 1'b1;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [63:0] key_low;
      logic [55:0] key_high;
      logic [15:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  slot;
      logic [15:0] found_handle;
   } rsp_type;

   // classified item handed from the hash front to the probe back
   typedef struct packed {
      logic        kind;
      logic [63:0] key_low;
      logic [55:0] key_high;
      logic [15:0] entry_handle;
      logic [31:0] hash;
   } job_type;

endpackage

// ===== rtl/core/dhskt_front.sv =====
// ----------------------------------------------------------------------------
// dhskt_front
// Byte-serial key normalization and FNV-1a hash, one byte per cycle.
// ----------------------------------------------------------------------------
module dhskt_front #(
   parameter int KEY_BYTES = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dhskt_pkg::req_type req_data,
   output logic               job_valid,
   input  logic               job_stall,
   output dhskt_pkg::job_type job_data
);

   localparam int NB = (KEY_BYTES < dhskt_pkg::MAX_KEY_BYTES) ?
                       KEY_BYTES : dhskt_pkg::MAX_KEY_BYTES;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HASH = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [3:0]           idx_ff, idx_in;
   logic [119:0]         key_ff, key_in;
   logic [119:0]         nkey_ff, nkey_in;
   logic [31:0]          hash_ff, hash_in;
   logic                 kind_ff, kind_in;
   logic [15:0]          hdl_ff, hdl_in;
   logic [7:0]           cur_byte;
   logic [31:0]          mixed;

   assign cur_byte = key_ff[{idx_ff, 3'b000} +: 8];
   assign mixed    = hash_ff ^ {24'd0, cur_byte};

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      nkey_in  = nkey_ff;
      hash_in  = hash_ff;
      kind_in  = kind_ff;
      hdl_in   = hdl_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = {req_data.key_high, req_data.key_low};
               kind_in  = req_data.kind;
               hdl_in   = req_data.entry_handle;
               nkey_in  = '0;
               hash_in  = dhskt_pkg::FNV_BASIS;
               idx_in   = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (cur_byte == 8'd0) begin
               state_in = S_DONE;
            end else begin
               hash_in = mixed * dhskt_pkg::FNV_PRIME;
               nkey_in[{idx_ff, 3'b000} +: 8] = cur_byte;
               idx_in  = idx_ff + 4'd1;
               if (idx_ff == 4'(NB - 1)) state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!job_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
      idx_ff  <= idx_in;
      key_ff  <= key_in;
      nkey_ff <= nkey_in;
      hash_ff <= hash_in;
      kind_ff <= kind_in;
      hdl_ff  <= hdl_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign job_valid = (state_ff == S_DONE);
   always_comb begin
      job_data.kind         = kind_ff;
      job_data.key_low      = nkey_ff[63:0];
      job_data.key_high     = nkey_ff[119:64];
      job_data.entry_handle = hdl_ff;
      job_data.hash         = hash_ff;
   end

endmodule

// ===== rtl/core/dhskt_queue.sv =====
// ----------------------------------------------------------------------------
// dhskt_queue
// Two-entry queue between the hash front and the probe back.
// ----------------------------------------------------------------------------
module dhskt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  dhskt_pkg::job_type in_data,
   output logic               out_valid,
   input  logic               out_stall,
   output dhskt_pkg::job_type out_data
);

   dhskt_pkg::job_type mem_ff [2];
   logic               wp_ff, rp_ff;
   logic [1:0]         cnt_ff;
   logic               push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

endmodule

// ===== rtl/core/dhskt_back.sv =====
// ----------------------------------------------------------------------------
// dhskt_back
// Probe sequencer over the slot memory; each slot read goes through a read state and a check state.
// ----------------------------------------------------------------------------
module dhskt_back #(
   parameter int TABLE_SIZE_LOG2 = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_stall,
   input  dhskt_pkg::job_type job_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dhskt_pkg::rsp_type rsp_data
);

   localparam int          TS   = 1 << TABLE_SIZE_LOG2;
   localparam int          AW   = TABLE_SIZE_LOG2;
   localparam logic [AW:0] HALF = (AW + 1)'(TS / 2);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [135:0] ent_mem [TS];
   logic         used_mem [TS];
   logic [135:0] ent_rd_ff;
   logic         used_rd_ff;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [AW-1:0]      step_ff, step_in;
   logic [AW:0]        n_ff, n_in;
   logic [AW:0]        occ_ff, occ_in;
   dhskt_pkg::job_type job_ff, job_in;
   dhskt_pkg::rsp_type out_ff, out_in;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               wr_used;
   logic [AW-1:0]      step_w;

   assign step_w = job_data.hash[31 -: AW] | AW'(1);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      occ_in   = occ_ff;
      job_in   = job_ff;
      out_in   = out_ff;
      wr_en    = 1'b0;
      wr_addr  = cur_ff;
      wr_used  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            cur_in  = cur_ff + AW'(1);
            if (cur_ff == AW'(TS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (job_valid) begin
               job_in  = job_data;
               step_in = step_w;
               cur_in  = job_data.hash[AW-1:0] + step_w;
               n_in    = '0;
               if (job_data.kind == dhskt_pkg::KIND_INSERT && occ_ff >= HALF) begin
                  out_in   = '{dhskt_pkg::ST_FULL, 8'd0, 16'd0};
                  state_in = S_OUT;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (!used_rd_ff) begin
               if (job_ff.kind == dhskt_pkg::KIND_INSERT) begin
                  wr_en   = 1'b1;
                  wr_used = 1'b1;
                  occ_in  = occ_ff + (AW + 1)'(1);
                  out_in  = '{dhskt_pkg::ST_INSERTED, 8'(cur_ff), 16'd0};
               end else begin
                  out_in  = '{dhskt_pkg::ST_NOT_FOUND, 8'd0, 16'd0};
               end
               state_in = S_OUT;
            end else if (job_ff.kind == dhskt_pkg::KIND_SEARCH &&
                         ent_rd_ff[135:16] == {job_ff.key_high, job_ff.key_low}) begin
               out_in   = '{dhskt_pkg::ST_FOUND, 8'(cur_ff), ent_rd_ff[15:0]};
               state_in = S_OUT;
            end else if (n_ff == (AW + 1)'(TS - 1)) begin
               out_in   = (job_ff.kind == dhskt_pkg::KIND_INSERT) ?
                          '{dhskt_pkg::ST_FULL, 8'd0, 16'd0} :
                          '{dhskt_pkg::ST_NOT_FOUND, 8'd0, 16'd0};
               state_in = S_OUT;
            end else begin
               cur_in   = cur_ff + step_ff;
               n_in     = n_ff + (AW + 1)'(1);
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cur_ff   <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         occ_ff   <= occ_in;
      end
      step_ff <= step_in;
      n_ff    <= n_in;
      job_ff  <= job_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem[wr_addr] <= wr_used;
      end
      if (wr_en && wr_used) begin
         ent_mem[wr_addr] <= {job_ff.key_high, job_ff.key_low, job_ff.entry_handle};
      end
      used_rd_ff <= used_mem[cur_ff];
      ent_rd_ff  <= ent_mem[cur_ff];
   end

   assign job_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/double_hash_string_key_table.sv =====
// Flow: the front hashes the key byte by byte up to a zero byte or the
// key-length limit, then each probe reads and checks one slot. The hash
// front and probe back overlap through a two-entry queue, so throughput
// is set by the slower.
// Reset: synchronous; the slot-used memory is cleared by a pass over all
// 2**TABLE_SIZE_LOG2 slots after reset, during which items are hashed and
// queued but none is probed.
// ----------------------------------------------------------------------------
// double_hash_string_key_table
// Open-addressed string key table with FNV-1a double hashing.
// ----------------------------------------------------------------------------
module double_hash_string_key_table #(
   parameter int TABLE_SIZE_LOG2 = 8,
   parameter int KEY_BYTES       = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dhskt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dhskt_pkg::rsp_type rsp_data
);

   logic               f_valid, f_stall, b_valid, b_stall, fr_stall;
   dhskt_pkg::job_type f_data, b_data;

   dhskt_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall(fr_stall), .req_data,
      .job_valid(f_valid), .job_stall(f_stall), .job_data(f_data)
   );

   dhskt_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
   );

   dhskt_back #(.TABLE_SIZE_LOG2(TABLE_SIZE_LOG2)) u_back (
      .clock, .reset, .job_valid(b_valid), .job_stall(b_stall), .job_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

   assign req_stall = fr_stall;

endmodule

// ===== rtl/core/dhskt_checker.sv =====
// ----------------------------------------------------------------------------
// dhskt_checker
// Port-level checks on the key table.
// ----------------------------------------------------------------------------
module dhskt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input dhskt_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == dhskt_pkg::ST_NOT_FOUND |->
      rsp_data.slot == 8'd0 && rsp_data.found_handle == 16'd0)
      else $error("not found carries data");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == dhskt_pkg::ST_FULL ||
                    rsp_data.status == dhskt_pkg::ST_INSERTED) |->
      rsp_data.found_handle == 16'd0)
      else $error("handle on non-found status");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while hashing");

endmodule

bind double_hash_string_key_table dhskt_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

// ===== test/tb_double_hash_string_key_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_hash_string_key_table
// Self-checking bench for the string key table: directed inserts and searches,
// a fill to the limit, a receiver hold-off, then random traffic mostly over a
// small key pool, each checked against a behavioral FNV-1a double-hash table.
// ----------------------------------------------------------------------------
module tb_double_hash_string_key_table;

   localparam int SIZE_LOG2 = 8;
   localparam int SIZE      = 1 << SIZE_LOG2;
   localparam int WATCHDOG  = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   dhskt_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   dhskt_pkg::rsp_type rsp_data;

   double_hash_string_key_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // behavioral table
   logic               used_q[SIZE];
   logic [63:0]        key_low_q[SIZE];
   logic [55:0]        key_high_q[SIZE];
   logic [15:0]        handle_q[SIZE];
   int                 fill_count;
   dhskt_pkg::rsp_type expected_rsp[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_off = 1'b0;
   int  failures = 0;
   int  quiet_cycles = 0;

   function automatic logic [31:0] key_trim(inout logic [63:0] lo,
                                            inout logic [55:0] hi);
      logic [31:0]  h;
      logic [119:0] raw;
      logic [119:0] kept;
      logic [7:0]   b;
      h = dhskt_pkg::FNV_BASIS;
      raw = {hi, lo};
      kept = '0;
      for (int i = 0; i < dhskt_pkg::MAX_KEY_BYTES; i++) begin
         b = raw[8*i +: 8];
         if (b == 8'd0) break;
         h = (h ^ {24'd0, b}) * dhskt_pkg::FNV_PRIME;
         kept[8*i +: 8] = b;
      end
      lo = kept[63:0];
      hi = kept[119:64];
      return h;
   endfunction

   function automatic dhskt_pkg::rsp_type table_lookup(dhskt_pkg::req_type r);
      dhskt_pkg::rsp_type o;
      logic [63:0] lo;
      logic [55:0] hi;
      logic [31:0] h;
      logic [7:0]  stride;
      logic [7:0]  at;
      lo = r.key_low;
      hi = r.key_high;
      h = key_trim(lo, hi);
      stride = h[31:24] | 8'd1;
      at = h[7:0] + stride;
      o = '{status: dhskt_pkg::ST_NOT_FOUND, slot: 8'd0, found_handle: 16'd0};
      if (r.kind == dhskt_pkg::KIND_INSERT) begin
         if (fill_count >= SIZE / 2) begin
            o.status = dhskt_pkg::ST_FULL;
            return o;
         end
         while (used_q[at]) at = at + stride;
         used_q[at] = 1'b1;
         key_low_q[at] = lo;
         key_high_q[at] = hi;
         handle_q[at] = r.entry_handle;
         fill_count++;
         o.status = dhskt_pkg::ST_INSERTED;
         o.slot = at;
         return o;
      end
      for (int n = 0; n < SIZE && used_q[at]; n++) begin
         if (key_low_q[at] == lo && key_high_q[at] == hi) begin
            o.status = dhskt_pkg::ST_FOUND;
            o.slot = at;
            o.found_handle = handle_q[at];
            return o;
         end
         at = at + stride;
      end
      return o;
   endfunction

   // drive one transfer; a typed expectation overrides the predicted one
   task automatic send_item(dhskt_pkg::req_type r, bit has_fixed,
                            dhskt_pkg::rsp_type fixed);
      dhskt_pkg::rsp_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = table_lookup(r);
      if (has_fixed && p != fixed)
         $error("directed row disagrees with table: expected %h predicted %h", fixed, p);
      expected_rsp.push_back(has_fixed ? fixed : p);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      dhskt_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("transfer with no expectation: %h", rsp_data);
            failures++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.status != e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.slot != e.slot) begin
               $error("slot expected %0d actual %0d", e.slot, rsp_data.slot);
               failures++;
            end
            if (rsp_data.found_handle != e.found_handle) begin
               $error("found_handle expected %h actual %h", e.found_handle,
                      rsp_data.found_handle);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // key pool: random names with varied length and junk past the terminator
   logic [63:0] pool_low[24];
   logic [55:0] pool_high[24];

   function automatic dhskt_pkg::req_type pool_req(int idx, logic kind);
      dhskt_pkg::req_type r;
      r.kind = kind;
      r.key_low = pool_low[idx];
      r.key_high = pool_high[idx];
      if ($urandom_range(3) == 0) begin
         r.key_low = r.key_low | ({$urandom, $urandom} & ~({64{1'b1}} >> 0) );
      end
      r.entry_handle = 16'($urandom);
      return r;
   endfunction

   typedef struct {
      dhskt_pkg::req_type r;
      bit                 has_fixed;
      dhskt_pkg::rsp_type fixed;
   } row_type;

   initial begin
      row_type            rows[$];
      dhskt_pkg::req_type r;
      int                 len;
      logic [119:0]       k;

      for (int i = 0; i < SIZE; i++) used_q[i] = 1'b0;
      fill_count = 0;
      for (int i = 0; i < 24; i++) begin
         len = (i == 0) ? 0 : $urandom_range(15, 1);
         k = 120'({$urandom, $urandom, $urandom, $urandom});
         for (int b = 0; b < 15; b++)
            if (b < len && k[8*b +: 8] == 8'd0) k[8*b +: 8] = 8'hA5;
         if (len < 15) k[8*len +: 8] = 8'd0;
         pool_low[i] = k[63:0];
         pool_high[i] = k[119:64];
      end

      rows.push_back('{'{dhskt_pkg::KIND_SEARCH, 64'h41, 56'd0, 16'd0}, 1,
                       '{dhskt_pkg::ST_NOT_FOUND, 8'd0, 16'd0}});
      rows.push_back('{'{dhskt_pkg::KIND_INSERT, 64'd0, 56'd0, 16'hFFFF}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_SEARCH, 64'd0, {56{1'b1}}, 16'h1234}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_INSERT, {64{1'b1}}, {56{1'b1}}, 16'h0000}, 0,
                       '0});
      rows.push_back('{'{dhskt_pkg::KIND_SEARCH, {64{1'b1}}, {56{1'b1}}, 16'h0000}, 0,
                       '0});
      rows.push_back('{'{dhskt_pkg::KIND_INSERT, 64'h0000_00FF_0061_6263, {56{1'b1}},
                         16'h00AA}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_SEARCH, 64'h0000_0000_0061_6263, 56'd0,
                         16'd0}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_INSERT, 64'h0000_0000_0061_6263, 56'd0,
                         16'h5555}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_SEARCH, 64'h0000_0000_0061_6263, 56'h77,
                         16'd0}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_SEARCH, 64'h0102_0304_0506_0708, 56'h0,
                         16'd0}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_INSERT, 64'h8080_8080_8080_8080,
                         56'h80_8080_8080_8080, 16'h8000}, 0, '0});
      rows.push_back('{'{dhskt_pkg::KIND_SEARCH, 64'h8080_8080_8080_8080,
                         56'h80_8080_8080_8080, 16'd0}, 0, '0});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_item(rows[i].r, rows[i].has_fixed, rows[i].fixed);

      // fill to the limit, then see refusals
      while (fill_count < SIZE / 2) begin
         r = '{dhskt_pkg::KIND_INSERT, {$urandom, $urandom}, 56'({$urandom, $urandom}),
               16'($urandom)};
         send_item(r, 0, '0);
      end
      send_item('{dhskt_pkg::KIND_INSERT, 64'h42, 56'd0, 16'h0001}, 1,
                '{dhskt_pkg::ST_FULL, 8'd0, 16'd0});
      send_item('{dhskt_pkg::KIND_INSERT, {64{1'b1}}, {56{1'b1}}, 16'hFFFF}, 1,
                '{dhskt_pkg::ST_FULL, 8'd0, 16'd0});

      // long receiver hold-off while offering items
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 8; i++)
            send_item(pool_req($urandom_range(23), dhskt_pkg::KIND_SEARCH), 0, '0);
      join

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 29 : 0;
         for (int i = 0; i < 150; i++) begin
            case ($urandom_range(9))
               0: r = '{1'($urandom), {$urandom, $urandom}, 56'({$urandom, $urandom}),
                        16'($urandom)};
               1, 2: r = pool_req($urandom_range(23), dhskt_pkg::KIND_INSERT);
               default: r = pool_req($urandom_range(23), dhskt_pkg::KIND_SEARCH);
            endcase
            send_item(r, 0, '0);
         end
      end
      req_valid <= 1'b0;
      recv_idle_pct = 0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0 && expected_rsp.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/dhskt_pkg.sv
rtl/core/dhskt_front.sv
rtl/core/dhskt_queue.sv
rtl/core/dhskt_back.sv
rtl/core/double_hash_string_key_table.sv
rtl/core/dhskt_checker.sv
test/tb_double_hash_string_key_table.sv
